FILE: rtl/pcd_pkg.sv
`timescale 1ns / 1ps
// Package for the pausable countdown timer: state, status, item kind and
// action codes, plus the bit layout of the request and response items.
// No dependencies.
package pcd_pkg;

   localparam int TIME_W = 64;
   localparam int ACT_W  = 8;
   localparam int ST_W   = 3;
   localparam int STS_W  = 3;
   localparam int KIND_W = 2;

   // Timer states
   localparam logic [ST_W-1:0] ST_IDLE      = 3'd0;
   localparam logic [ST_W-1:0] ST_RUNNING   = 3'd1;
   localparam logic [ST_W-1:0] ST_PAUSED    = 3'd2;
   localparam logic [ST_W-1:0] ST_COMPLETED = 3'd3;
   localparam logic [ST_W-1:0] ST_CANCELLED = 3'd4;

   // Response status codes
   localparam logic [STS_W-1:0] RC_OK       = 3'd0;
   localparam logic [STS_W-1:0] RC_INVALID  = 3'd1;
   localparam logic [STS_W-1:0] RC_STALE    = 3'd2;
   localparam logic [STS_W-1:0] RC_OVERFLOW = 3'd3;
   localparam logic [STS_W-1:0] RC_AGAIN    = 3'd4;
   localparam logic [STS_W-1:0] RC_BUSY     = 3'd5;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CANCEL   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SNAPSHOT = 2'd3;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_START  = 8'd1;
   localparam logic [ACT_W-1:0] ACT_PAUSE  = 8'd2;
   localparam logic [ACT_W-1:0] ACT_RESUME = 8'd3;
   localparam logic [ACT_W-1:0] ACT_CANCEL = 8'd4;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Request item layout (tdata), lowest bit first
   localparam int REQ_NOW_LSB = 0;
   localparam int REQ_ACT_LSB = REQ_NOW_LSB + TIME_W;
   localparam int REQ_REV_LSB = REQ_ACT_LSB + ACT_W;
   localparam int REQ_OP_LSB  = REQ_REV_LSB + TIME_W;
   localparam int REQ_DUR_LSB = REQ_OP_LSB + TIME_W;
   localparam int REQ_BITS    = REQ_DUR_LSB + TIME_W;
   localparam int REQ_W       = ((REQ_BITS + 7) / 8) * 8;

   // Response item layout (tdata), lowest bit first
   localparam int RSP_STS_LSB = 0;
   localparam int RSP_FIRE_LSB = RSP_STS_LSB + STS_W;
   localparam int RSP_ST_LSB  = RSP_FIRE_LSB + 1;
   localparam int RSP_REV_LSB = RSP_ST_LSB + ST_W;
   localparam int RSP_REM_LSB = RSP_REV_LSB + TIME_W;
   localparam int RSP_DUR_LSB = RSP_REM_LSB + TIME_W;
   localparam int RSP_BITS    = RSP_DUR_LSB + TIME_W;
   localparam int RSP_W       = ((RSP_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/pausable_countdown_timer.sv
`timescale 1ns / 1ps
// Top level of the pausable countdown timer: input register, request
// evaluation and result register. Depends on pcd_pkg.

// Every item (tick, request, forced cancel or snapshot) carries the current
// time in ms and yields exactly one response item with status, fired flag,
// timer state, revision, remaining time and countdown duration. The block
// takes one item per clock cycle while responses are taken: an item is
// captured in the input register, evaluated against the timer state in one
// pass of compares and 64-bit adds, and written to the result register
// once it is free. The result register sets the pace: while a response waits
// on rsp_tready the input register still holds one more item, and the
// input side stalls only once both are full. Requests are checked in a
// fixed order (malformed, exact replay, stale revision, revision at
// maximum, time going backwards, then per-action checks); an exact replay
// of the last accepted request answers ok and changes nothing. The revision
// saturates at its maximum. After reset the timer is idle with all
// counters and times at zero.
module pausable_countdown_timer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // now[63:0], action[71:64], req_revision[135:72], operation[199:136],
   // duration[263:200]
   input  logic [pcd_pkg::REQ_W-1:0]    req_tdata,
   // req_type[1:0]
   input  logic [pcd_pkg::KIND_W-1:0]   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // status[2:0], fired[3], state_out[6:4], revision_out[70:7],
   // remaining_out[134:71], duration_out[198:135], zero pad[199]
   output logic [pcd_pkg::RSP_W-1:0]    rsp_tdata
);
   import pcd_pkg::*;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [REQ_W-1:0]     in_tdata_ff;
   logic [KIND_W-1:0]    in_tuser_ff;

   // Result register
   logic                 out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]     out_tdata_ff, out_tdata_in;

   // Timer state
   logic [ST_W-1:0]      state_ff, state_in;
   logic [TIME_W-1:0]    revision_ff, revision_in;
   logic [TIME_W-1:0]    run_duration_ff, run_duration_in;
   logic [TIME_W-1:0]    paused_rem_ff, paused_rem_in;
   logic [TIME_W-1:0]    deadline_ff, deadline_in;
   logic [TIME_W-1:0]    last_seen_ff, last_seen_in;
   logic [ACT_W-1:0]     prev_action_ff, prev_action_in;
   logic [TIME_W-1:0]    prev_revision_ff, prev_revision_in;
   logic [TIME_W-1:0]    prev_operation_ff, prev_operation_in;
   logic [TIME_W-1:0]    prev_duration_ff, prev_duration_in;
   logic                 prev_valid_ff, prev_valid_in;

   // Fields of the held item
   logic [TIME_W-1:0]    now;
   logic [ACT_W-1:0]     action;
   logic [TIME_W-1:0]    req_revision;
   logic [TIME_W-1:0]    operation;
   logic [TIME_W-1:0]    duration;

   logic                 advance;
   logic                 time_back;
   logic                 past_deadline;
   logic                 active;
   logic [TIME_W:0]      start_sum;
   logic [TIME_W:0]      resume_sum;
   logic                 malformed;
   logic                 replay;
   logic                 accept;
   logic [STS_W-1:0]     status;
   logic                 fired;
   logic [TIME_W-1:0]    eval_time;
   logic [TIME_W-1:0]    remaining;

   assign now          = in_tdata_ff[REQ_NOW_LSB +: TIME_W];
   assign action       = in_tdata_ff[REQ_ACT_LSB +: ACT_W];
   assign req_revision = in_tdata_ff[REQ_REV_LSB +: TIME_W];
   assign operation    = in_tdata_ff[REQ_OP_LSB +: TIME_W];
   assign duration     = in_tdata_ff[REQ_DUR_LSB +: TIME_W];

   // Move the held item to the result register when that register is free
   // or being drained this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_tdata_ff;

   assign time_back     = now < last_seen_ff;
   assign past_deadline = now >= deadline_ff;
   assign active        = (state_ff == ST_RUNNING) || (state_ff == ST_PAUSED);
   assign start_sum     = {1'b0, now} + {1'b0, duration};
   assign resume_sum    = {1'b0, now} + {1'b0, paused_rem_ff};

   assign malformed = !(action inside {[ACT_START:ACT_CANCEL]}) || (operation == '0) ||
                      ((action == ACT_START) && (duration == '0)) ||
                      ((action != ACT_START) && (duration != '0));
   assign replay    = prev_valid_ff && (action == prev_action_ff) &&
                      (req_revision == prev_revision_ff) &&
                      (operation == prev_operation_ff) && (duration == prev_duration_ff);

   // Evaluate the held item and form the next timer state.
   always_comb begin
      state_in          = state_ff;
      revision_in       = revision_ff;
      run_duration_in   = run_duration_ff;
      paused_rem_in     = paused_rem_ff;
      deadline_in       = deadline_ff;
      last_seen_in      = last_seen_ff;
      prev_action_in    = prev_action_ff;
      prev_revision_in  = prev_revision_ff;
      prev_operation_in = prev_operation_ff;
      prev_duration_in  = prev_duration_ff;
      prev_valid_in     = prev_valid_ff;
      status            = RC_OK;
      fired             = 1'b0;
      accept            = 1'b0;

      case (in_tuser_ff)
         KIND_TICK: begin
            // Drop ticks that go back in time.
            if (!time_back) begin
               last_seen_in = now;
               if ((state_ff == ST_RUNNING) && past_deadline) begin
                  state_in      = ST_COMPLETED;
                  paused_rem_in = '0;
                  fired         = 1'b1;
                  if (revision_ff != TIME_MAX) revision_in = revision_ff + 1'b1;
               end
            end
         end
         KIND_REQUEST: begin
            if (malformed) begin
               status = RC_INVALID;
            end else if (replay) begin
               status = RC_OK;
            end else if (req_revision != revision_ff) begin
               status = RC_STALE;
            end else if (revision_ff == TIME_MAX) begin
               status = RC_OVERFLOW;
            end else if (time_back) begin
               status = RC_AGAIN;
            end else begin
               case (action)
                  ACT_START: begin
                     if (active) begin
                        status = RC_BUSY;
                     end else if (start_sum[TIME_W]) begin
                        status = RC_OVERFLOW;
                     end else begin
                        accept          = 1'b1;
                        run_duration_in = duration;
                        deadline_in     = start_sum[TIME_W-1:0];
                        state_in        = ST_RUNNING;
                     end
                  end
                  ACT_PAUSE: begin
                     if (state_ff != ST_RUNNING) begin
                        status = RC_INVALID;
                     end else if (past_deadline) begin
                        status = RC_AGAIN;
                     end else begin
                        accept        = 1'b1;
                        paused_rem_in = deadline_ff - now;
                        state_in      = ST_PAUSED;
                     end
                  end
                  ACT_RESUME: begin
                     if (state_ff != ST_PAUSED) begin
                        status = RC_INVALID;
                     end else if (resume_sum[TIME_W]) begin
                        status = RC_OVERFLOW;
                     end else begin
                        accept      = 1'b1;
                        deadline_in = resume_sum[TIME_W-1:0];
                        state_in    = ST_RUNNING;
                     end
                  end
                  default: begin
                     // Cancel; other actions were rejected as malformed.
                     if (!active) begin
                        status = RC_INVALID;
                     end else begin
                        accept        = 1'b1;
                        paused_rem_in = '0;
                        state_in      = ST_CANCELLED;
                     end
                  end
               endcase
               if (accept) begin
                  last_seen_in      = now;
                  revision_in       = revision_ff + 1'b1;
                  prev_action_in    = action;
                  prev_revision_in  = req_revision;
                  prev_operation_in = operation;
                  prev_duration_in  = duration;
                  prev_valid_in     = 1'b1;
               end
            end
         end
         KIND_CANCEL: begin
            // Forced cancel acts only on a live countdown and forgets the
            // stored request; the item time is not recorded.
            if (active) begin
               state_in      = ST_CANCELLED;
               paused_rem_in = '0;
               prev_valid_in = 1'b0;
               if (revision_ff != TIME_MAX) revision_in = revision_ff + 1'b1;
            end
         end
         default: begin
            // Snapshot: report only.
         end
      endcase
   end

   // Remaining time after the item, taken at the later of the item time
   // and the last time seen.
   assign eval_time = (now < last_seen_in) ? last_seen_in : now;

   always_comb begin
      case (state_in)
         ST_RUNNING: remaining = (eval_time < deadline_in) ? deadline_in - eval_time : '0;
         ST_PAUSED:  remaining = paused_rem_in;
         default:    remaining = '0;
      endcase
   end

   always_comb begin
      out_tdata_in = '0;
      out_tdata_in[RSP_STS_LSB +: STS_W]  = status;
      out_tdata_in[RSP_FIRE_LSB]          = fired;
      out_tdata_in[RSP_ST_LSB +: ST_W]    = state_in;
      out_tdata_in[RSP_REV_LSB +: TIME_W] = revision_in;
      out_tdata_in[RSP_REM_LSB +: TIME_W] = remaining;
      out_tdata_in[RSP_DUR_LSB +: TIME_W] = run_duration_in;
   end

   assign in_valid_in  = req_tvalid || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         state_ff          <= ST_IDLE;
         revision_ff       <= '0;
         run_duration_ff   <= '0;
         paused_rem_ff     <= '0;
         deadline_ff       <= '0;
         last_seen_ff      <= '0;
         prev_action_ff    <= '0;
         prev_revision_ff  <= '0;
         prev_operation_ff <= '0;
         prev_duration_ff  <= '0;
         prev_valid_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // Commit the timer state only when the item moves on.
         if (advance) begin
            state_ff          <= state_in;
            revision_ff       <= revision_in;
            run_duration_ff   <= run_duration_in;
            paused_rem_ff     <= paused_rem_in;
            deadline_ff       <= deadline_in;
            last_seen_ff      <= last_seen_in;
            prev_action_ff    <= prev_action_in;
            prev_revision_ff  <= prev_revision_in;
            prev_operation_ff <= prev_operation_in;
            prev_duration_ff  <= prev_duration_in;
            prev_valid_ff     <= prev_valid_in;
         end
      end
   end

   // Payload registers: load on acceptance / advance, no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_tdata_ff <= req_tdata;
         in_tuser_ff <= req_tuser;
      end
      if (advance) begin
         out_tdata_ff <= out_tdata_in;
      end
   end

endmodule

FILE: rtl/pcd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the pausable countdown timer, bound to the top
// level. Depends on pcd_pkg.
module pcd_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [pcd_pkg::RSP_W-1:0] rsp_tdata
);
   import pcd_pkg::*;

   logic [STS_W-1:0]  status;
   logic              fired;
   logic [ST_W-1:0]   state_out;
   logic [TIME_W-1:0] remaining_out;

   assign status        = rsp_tdata[RSP_STS_LSB +: STS_W];
   assign fired         = rsp_tdata[RSP_FIRE_LSB];
   assign state_out     = rsp_tdata[RSP_ST_LSB +: ST_W];
   assign remaining_out = rsp_tdata[RSP_REM_LSB +: TIME_W];

   // A stalled response item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response item changed while stalled");

   // No response item right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A firing tick always leaves the timer completed with ok status.
   a_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && fired |-> (state_out == ST_COMPLETED) && (status == RC_OK))
      else $error("fired without completing");

   // Remaining time is zero unless a countdown is live.
   a_rem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (state_out != ST_RUNNING) && (state_out != ST_PAUSED)
      |-> (remaining_out == '0))
      else $error("remaining time nonzero in a settled state");

endmodule

bind pausable_countdown_timer pcd_checker u_pcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
